// ===== hw/rtl/rfpe_pkg.sv =====
// shared types, constants and helpers for the remote frame pulse encoder
// no dependencies; imported by rfpe_front, rfpe_back and the top level
`timescale 1ns / 1ps

package rfpe_pkg;

  localparam int CmdW    = 7;
  localparam int AddrW   = 7;
  localparam int RepW    = 4;
  localparam int TickW   = 8;
  localparam int BitPosW = 5;
  localparam int PaddrW  = 4;
  localparam int PdataW  = 32;

  // bit positions within one frame
  localparam logic [BitPosW-1:0] FirstAddrBit = 5'd1;
  localparam logic [BitPosW-1:0] LastAddrBit  = 5'd7;
  localparam logic [BitPosW-1:0] FirstCmdBit  = 5'd8;
  localparam logic [BitPosW-1:0] LastCmdBit   = 5'd14;
  localparam logic [BitPosW-1:0] LastBit      = 5'd16;

  // register reset values
  localparam logic [AddrW-1:0] AddrReset    = 7'h47;
  localparam logic [RepW-1:0]  RepReset     = 4'd3;
  localparam logic [TickW-1:0] AgcLowReset  = 8'd16;
  localparam logic [TickW-1:0] AgcHighReset = 8'd8;

  // segment lengths of one data bit
  localparam logic [TickW-1:0] OneTick    = 8'd1;
  localparam logic [TickW-1:0] ThreeTicks = 8'd3;

  // request queue between front and back
  localparam logic [1:0] QueueFull = 2'd2;

  typedef enum logic {
    ITEM_TICK = 1'b0,
    ITEM_LOAD = 1'b1
  } rfpe_kind_t;

  typedef struct packed {
    rfpe_kind_t       kind;
    logic [CmdW-1:0]  command;
  } rfpe_item_t;

  typedef struct packed {
    logic [AddrW-1:0] device_address;
    logic [RepW-1:0]  repeat_count;
    logic [TickW-1:0] agc_low_ticks;
    logic [TickW-1:0] agc_high_ticks;
  } rfpe_cfg_t;

  typedef enum logic [1:0] {
    REG_ADDR     = 2'd0,
    REG_REPEAT   = 2'd1,
    REG_AGC_LOW  = 2'd2,
    REG_AGC_HIGH = 2'd3
  } rfpe_reg_t;

  // zero lengths act as one
  function automatic logic [TickW-1:0] ticks_at_least_one(input logic [TickW-1:0] v);
    ticks_at_least_one = (v == '0) ? OneTick : v;
  endfunction

  function automatic logic [RepW-1:0] rep_at_least_one(input logic [RepW-1:0] v);
    rep_at_least_one = (v == '0) ? 4'd1 : v;
  endfunction

endpackage

// ===== hw/rtl/remote_frame_pulse_encoder.sv =====
// top level of the remote frame pulse encoder: register file, front end and back end
// depends on rfpe_pkg, rfpe_front and rfpe_back
// a request is written into the queue on acceptance and its result into the output register when popped
// throughput: one request per cycle while out_ready does not stall the output; the frame sequencer
// handles one request a cycle and a two-entry queue plus the output register keep input and output apart
// reset: synchronous active-low rst_n; registers return to address 0x47, three frames,
// agc 16 low / 8 high; sequencer idle with the line released, queue and output empty
`timescale 1ns / 1ps

module remote_frame_pulse_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [rfpe_pkg::CmdW-1:0]     in_command,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_line_level,
  output logic                          out_busy_res,
  output logic                          out_load_accepted,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfpe_pkg::PaddrW-1:0]   paddr,
  input  logic [rfpe_pkg::PdataW-1:0]   pwdata,
  output logic [rfpe_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);
  import rfpe_pkg::*;

  rfpe_cfg_t   cfg_r, cfg_nxt;
  rfpe_reg_t   reg_sel;
  logic        reg_wr;
  logic        q_valid, q_ready;
  rfpe_item_t  q_item;

  // ---------------------------------------------------------------------------
  // register file: word addressed, low address bits ignored, no wait states
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = rfpe_reg_t'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (reg_wr) begin
      case (reg_sel)
        REG_ADDR:     cfg_nxt.device_address = pwdata[AddrW-1:0];
        REG_REPEAT:   cfg_nxt.repeat_count   = pwdata[RepW-1:0];
        REG_AGC_LOW:  cfg_nxt.agc_low_ticks  = pwdata[TickW-1:0];
        REG_AGC_HIGH: cfg_nxt.agc_high_ticks = pwdata[TickW-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  // readback, zero extended to the bus width
  always_comb begin
    case (reg_sel)
      REG_ADDR:     prdata = PdataW'(cfg_r.device_address);
      REG_REPEAT:   prdata = PdataW'(cfg_r.repeat_count);
      REG_AGC_LOW:  prdata = PdataW'(cfg_r.agc_low_ticks);
      REG_AGC_HIGH: prdata = PdataW'(cfg_r.agc_high_ticks);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= AddrReset;
      cfg_r.repeat_count   <= RepReset;
      cfg_r.agc_low_ticks  <= AgcLowReset;
      cfg_r.agc_high_ticks <= AgcHighReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // front end: classifies each request as tick or load and queues it
  // ---------------------------------------------------------------------------
  rfpe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_command (in_command),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_ready    (q_ready)
  );

  // ---------------------------------------------------------------------------
  // back end: frame sequencer (bus reset, agc header, 17 pulse-distance bits,
  // repeated per the repeat register) with the registered result
  // ---------------------------------------------------------------------------
  rfpe_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_ready           (q_ready),
    .cfg               (cfg_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_line_level    (out_line_level),
    .out_busy_res      (out_busy_res),
    .out_load_accepted (out_load_accepted)
  );

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a taken load already shows the released bus reset tick
  a_load_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_load_accepted |-> out_busy_res && out_line_level)
    else $error("accepted load without busy released line");

  // when no frame is in progress the line is released
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_line_level)
    else $error("line driven low while idle");

  // a request that reaches the back end with the output free shows up next cycle
  a_queue_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready |=> out_valid)
    else $error("popped request produced no result");

endmodule

// ===== hw/rtl/rfpe_front.sv =====
// front end: takes requests, classifies them and holds them in a two-entry queue
// depends on rfpe_pkg
`timescale 1ns / 1ps

module rfpe_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [rfpe_pkg::CmdW-1:0]   in_command,
  output logic                        q_valid,
  output rfpe_pkg::rfpe_item_t        q_item,
  input  logic                        q_ready
);
  import rfpe_pkg::*;

  rfpe_item_t  entry_r [2];
  rfpe_item_t  item;
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push, pop;

  // command only matters for a load
  always_comb begin
    item.kind    = in_op ? ITEM_LOAD : ITEM_TICK;
    item.command = in_op ? in_command : '0;
  end

  assign in_ready = (count_r != QueueFull);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = entry_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== hw/rtl/rfpe_back.sv =====
// back end: frame sequencer (one tick per tick request, a load starts a frame when idle) plus output register
// depends on rfpe_pkg
`timescale 1ns / 1ps

module rfpe_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  rfpe_pkg::rfpe_item_t   q_item,
  output logic                   q_ready,
  input  rfpe_pkg::rfpe_cfg_t    cfg,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_line_level,
  output logic                   out_busy_res,
  output logic                   out_load_accepted
);
  import rfpe_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_BRESET = 3'd1,
    PH_AGCLO  = 3'd2,
    PH_AGCHI  = 3'd3,
    PH_BITLO  = 3'd4,
    PH_BITHI  = 3'd5
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [TickW-1:0]    tick_left_r, tick_left_nxt, tick_dec;
  logic [BitPosW-1:0]  bit_pos_r, bit_pos_nxt;
  logic [RepW-1:0]     repeat_done_r, repeat_done_nxt, repeat_inc;
  logic [CmdW-1:0]     cmd_r, cmd_nxt;
  logic                line_r, line_nxt;
  logic                accepted;
  logic                pop;
  logic                out_valid_r, out_valid_nxt;
  logic                out_line_r, out_line_nxt;
  logic                out_busy_r, out_busy_nxt;
  logic                out_acc_r, out_acc_nxt;

  function automatic logic frame_bit(input logic [BitPosW-1:0] pos,
                                     input logic [AddrW-1:0]   addr,
                                     input logic [CmdW-1:0]    cmd);
    logic [BitPosW-1:0] idx;
    idx = '0;
    if (pos == '0 || pos > LastCmdBit) begin
      frame_bit = 1'b1;
    end else if (pos <= LastAddrBit) begin
      idx       = pos - FirstAddrBit;
      frame_bit = addr[idx[2:0]];
    end else begin
      idx       = pos - FirstCmdBit;
      frame_bit = cmd[idx[2:0]];
    end
  endfunction

  assign q_ready = !out_valid_r || out_ready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    phase_nxt       = phase_r;
    tick_left_nxt   = tick_left_r;
    bit_pos_nxt     = bit_pos_r;
    repeat_done_nxt = repeat_done_r;
    cmd_nxt         = cmd_r;
    line_nxt        = line_r;
    accepted        = 1'b0;
    tick_dec        = (tick_left_r != '0) ? tick_left_r - 8'd1 : '0;
    repeat_inc      = repeat_done_r + 4'd1;

    if (pop) begin
      if (q_item.kind == ITEM_LOAD) begin
        if (phase_r == PH_IDLE) begin
          cmd_nxt         = q_item.command;
          repeat_done_nxt = '0;
          bit_pos_nxt     = '0;
          phase_nxt       = PH_BRESET;
          tick_left_nxt   = OneTick;
          line_nxt        = 1'b1;
          accepted        = 1'b1;
        end
      end else if (phase_r != PH_IDLE) begin
        tick_left_nxt = tick_dec;
        if (tick_dec == '0) begin
          case (phase_r)
            PH_BRESET: begin
              phase_nxt     = PH_AGCLO;
              tick_left_nxt = ticks_at_least_one(cfg.agc_low_ticks);
              line_nxt      = 1'b0;
            end
            PH_AGCLO: begin
              phase_nxt     = PH_AGCHI;
              tick_left_nxt = ticks_at_least_one(cfg.agc_high_ticks);
              line_nxt      = 1'b1;
            end
            PH_AGCHI: begin
              bit_pos_nxt   = '0;
              phase_nxt     = PH_BITLO;
              tick_left_nxt = OneTick;
              line_nxt      = 1'b0;
            end
            PH_BITLO: begin
              phase_nxt     = PH_BITHI;
              tick_left_nxt = frame_bit(bit_pos_r, cfg.device_address, cmd_r)
                              ? ThreeTicks : OneTick;
              line_nxt      = 1'b1;
            end
            PH_BITHI: begin
              if (bit_pos_r < LastBit) begin
                bit_pos_nxt   = bit_pos_r + 5'd1;
                phase_nxt     = PH_BITLO;
                tick_left_nxt = OneTick;
                line_nxt      = 1'b0;
              end else if (repeat_inc >= rep_at_least_one(cfg.repeat_count)) begin
                repeat_done_nxt = '0;
                bit_pos_nxt     = '0;
                phase_nxt       = PH_IDLE;
                tick_left_nxt   = '0;
                line_nxt        = 1'b1;
              end else begin
                repeat_done_nxt = repeat_inc;
                phase_nxt       = PH_BRESET;
                tick_left_nxt   = OneTick;
                line_nxt        = 1'b1;
              end
            end
            default: begin
              phase_nxt     = PH_IDLE;
              tick_left_nxt = '0;
              line_nxt      = 1'b1;
            end
          endcase
        end
      end
    end

    // output register: refill on every pop, drain when taken
    out_valid_nxt = pop ? 1'b1 : (out_valid_r && !out_ready);
    out_line_nxt  = pop ? line_nxt : out_line_r;
    out_busy_nxt  = pop ? (phase_nxt != PH_IDLE) : out_busy_r;
    out_acc_nxt   = pop ? accepted : out_acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_left_r   <= '0;
      bit_pos_r     <= '0;
      repeat_done_r <= '0;
      cmd_r         <= '0;
      line_r        <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      tick_left_r   <= tick_left_nxt;
      bit_pos_r     <= bit_pos_nxt;
      repeat_done_r <= repeat_done_nxt;
      cmd_r         <= cmd_nxt;
      line_r        <= line_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_line_r <= out_line_nxt;
    out_busy_r <= out_busy_nxt;
    out_acc_r  <= out_acc_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_line_level    = out_line_r;
  assign out_busy_res      = out_busy_r;
  assign out_load_accepted = out_acc_r;

endmodule
